FILE: rtl/rtcc_pkg.sv
// State type, opcodes, status codes, calendar constants and month_len of the clock.
package rtcc_pkg;

  localparam int SEC_PER_MIN  = 60;
  localparam int SEC_PER_HOUR = 3600;
  localparam int SEC_PER_DAY  = 86400;
  localparam int MS_PER_SEC   = 1000;
  localparam int MS_PER_TENTH = 100;
  localparam int TRIM_UNLOCK  = 5;

  localparam logic [3:0] OP_SAMPLE   = 4'd0;
  localparam logic [3:0] OP_ADD_SEC  = 4'd1;
  localparam logic [3:0] OP_ADD_DAY  = 4'd2;
  localparam logic [3:0] OP_MON_UP   = 4'd3;
  localparam logic [3:0] OP_MON_DN   = 4'd4;
  localparam logic [3:0] OP_YEAR_UP  = 4'd5;
  localparam logic [3:0] OP_YEAR_DN  = 4'd6;
  localparam logic [3:0] OP_ZERO_SEC = 4'd7;
  localparam logic [3:0] OP_LOAD_SEC = 4'd8;
  localparam logic [3:0] OP_LOAD_DAY = 4'd9;

  localparam logic [1:0] ST_NONE     = 2'd0;
  localparam logic [1:0] ST_TENTH    = 2'd1;
  localparam logic [1:0] ST_SECOND   = 2'd2;
  localparam logic [1:0] ST_MIDNIGHT = 2'd3;

  typedef enum logic [3:0] {
    S_IDLE, S_EXEC, S_ADDS, S_HMOD, S_TDIV, S_TAPPLY, S_WRAP, S_SAT,
    S_LMOD, S_BINIT, S_YEAR, S_MON, S_WDAY, S_HOUR, S_MIN, S_OUT
  } rtcc_state_t;

  function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
    logic [4:0] len;
    case (m)
      4'd2:    len = leap ? 5'd29 : 5'd28;
      4'd4:    len = 5'd30;
      4'd6:    len = 5'd30;
      4'd9:    len = 5'd30;
      4'd11:   len = 5'd30;
      default: len = 5'd31;
    endcase
    return len;
  endfunction

endpackage

FILE: rtl/calendar_clock_with_drift_trim_unit.sv
// Calendar clock top level: sequencer around one shared accumulator adder.
// One transfer is taken at a time; out_tvalid rises once the hour remainder loops, the
// year walk from BASE_YEAR (at most 179 years at 16 counter bits) and the hour and
// minute split are done. The next input transfer is taken in the cycle after the result
// transfer. Synchronous active-low reset sets 00:00:00 on day 1 and clears the trim.
module calendar_clock_with_drift_trim_unit
  import rtcc_pkg::*;
#(
  parameter int BASE_YEAR      = 2020,
  parameter int DAY_COUNT_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [55:0] in_tdata,   // now_ms[31:0], amount[49:32], zero fill
  input  logic [3:0]  in_tuser,   // opcode[3:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [87:0] out_tdata,  // second_of_day, hour, minute, second, day_of_month,
                                  // month_number, year_number, day_of_year, weekday,
                                  // day_count, zero fill
  output logic [1:0]  out_tuser,  // status[1:0]
  input  logic        cfg_wen,
  input  logic [14:0] cfg_wdata
);

  localparam int DCB = DAY_COUNT_BITS;
  localparam int SDW = ((DCB > 17) ? DCB : 17) + 2;
  localparam int AW  = (SDW > 20) ? SDW : 20;
  localparam int YWC = $clog2(BASE_YEAR + (1 << DCB) / 365 + 2);
  localparam int YW  = (YWC > 12) ? YWC : 12;
  localparam int WRS = DCB + 4;
  localparam logic [WRS-1:0] K_W7 = WRS'(((1 << WRS) + 6) / 7);
  localparam int PY  = BASE_YEAR - 1;
  localparam logic BL = (BASE_YEAR % 4 == 0) && ((BASE_YEAR % 100 != 0) ||
                        (BASE_YEAR % 400 == 0));
  localparam logic PL = (PY % 4 == 0) && ((PY % 100 != 0) || (PY % 400 == 0));
  localparam logic signed [AW-1:0] K_HOUR = AW'(SEC_PER_HOUR);
  localparam logic signed [AW-1:0] K_DAY  = AW'(SEC_PER_DAY);
  localparam logic signed [AW-1:0] K_MIN  = AW'(SEC_PER_MIN);
  localparam logic signed [AW-1:0] K_MS   = AW'(MS_PER_SEC);
  localparam logic signed [AW-1:0] K_UNL  = AW'(TRIM_UNLOCK);
  localparam logic signed [AW-1:0] K_ONE  = AW'(1);
  localparam logic signed [AW-1:0] K_DMAX = AW'((1 << DCB) - 1);

  rtcc_state_t state_r, state_nxt;
  logic [3:0] op_r, op_nxt;
  logic [31:0] now_r, now_nxt;
  logic signed [17:0] amt_r, amt_nxt;
  logic signed [14:0] trim_r, trim_nxt;
  logic [31:0] tenth_r, tenth_nxt, smark_r, smark_nxt;
  logic [16:0] sec_r, sec_nxt;
  logic [DCB-1:0] days_r, days_nxt;
  logic locked_r, locked_nxt, leap_r, leap_nxt, pleap_r, pleap_nxt, pass2_r, pass2_nxt;
  logic [YW-1:0] year_r, year_nxt;
  logic [3:0] month_r, month_nxt;
  logic [4:0] day_r, day_nxt;
  logic [8:0] doy_r, doy_nxt;
  logic [1:0] y4_r, y4_nxt;
  logic [6:0] y100_r, y100_nxt;
  logic [8:0] y400_r, y400_nxt;
  logic signed [AW-1:0] acc_r, acc_nxt, opnd, sum;
  logic signed [AW-1:0] s_r, s_nxt;
  logic signed [2:0] q_r, q_nxt;
  logic [4:0] tq_r, tq_nxt;
  logic [1:0] status_r, status_nxt;
  logic [4:0] hour_r, hour_nxt;
  logic [5:0] min_r, min_nxt, second_r, second_nxt;
  logic [2:0] wday_r, wday_nxt;
  logic [DCB:0] wval_r, wval_nxt;
  logic ovalid_r, ovalid_nxt;

  logic signed [AW-1:0] days_ext, amt_ext, trim_mag, tq_s;
  logic [8:0] ylen;
  logic [4:0] mlen;
  logic [1:0] n4;
  logic [6:0] n100;
  logic [8:0] n400;
  logic [2*DCB+4:0] wprod;
  logic [DCB:0] wquo;
  logic [DCB+3:0] wq7, wdiff;
  logic [31:0] dt_tenth, dt_sec, rem32;
  logic [DCB+15:0] dc_ext;

  assign sum      = acc_r + opnd;
  assign days_ext = AW'({1'b0, days_r});
  assign amt_ext  = AW'(amt_r);
  assign trim_mag = trim_r[14] ? -AW'(trim_r) : AW'(trim_r);
  assign tq_s     = trim_r[14] ? -AW'({1'b0, tq_r}) : AW'({1'b0, tq_r});
  assign ylen     = leap_r ? 9'd366 : 9'd365;
  assign mlen     = month_len(month_r, leap_r);
  assign n4       = y4_r + 2'd1;
  assign n100     = (y100_r == 7'd99) ? 7'd0 : y100_r + 7'd1;
  assign n400     = (y400_r == 9'd399) ? 9'd0 : y400_r + 9'd1;
  assign wprod    = (2*DCB+5)'(wval_r) * (2*DCB+5)'(K_W7);
  assign wquo     = wprod[2*DCB+4:WRS];
  assign wq7      = {wquo, 3'b000} - {3'b000, wquo};
  assign wdiff    = {3'b000, wval_r} - wq7;
  assign dt_tenth = now_r - tenth_r;
  assign dt_sec   = now_r - smark_r;
  assign rem32    = 32'(acc_r);
  assign dc_ext   = {16'd0, days_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      trim_r   <= '0;
      tenth_r  <= '0;
      smark_r  <= '0;
      sec_r    <= '0;
      days_r   <= DCB'(1);
      locked_r <= 1'b0;
      year_r   <= YW'(BASE_YEAR);
      month_r  <= 4'd1;
      day_r    <= 5'd1;
      doy_r    <= 9'd1;
      leap_r   <= BL;
      pleap_r  <= PL;
      ovalid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      trim_r   <= trim_nxt;
      tenth_r  <= tenth_nxt;
      smark_r  <= smark_nxt;
      sec_r    <= sec_nxt;
      days_r   <= days_nxt;
      locked_r <= locked_nxt;
      year_r   <= year_nxt;
      month_r  <= month_nxt;
      day_r    <= day_nxt;
      doy_r    <= doy_nxt;
      leap_r   <= leap_nxt;
      pleap_r  <= pleap_nxt;
      ovalid_r <= ovalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r     <= op_nxt;
    now_r    <= now_nxt;
    amt_r    <= amt_nxt;
    y4_r     <= y4_nxt;
    y100_r   <= y100_nxt;
    y400_r   <= y400_nxt;
    acc_r    <= acc_nxt;
    s_r      <= s_nxt;
    q_r      <= q_nxt;
    tq_r     <= tq_nxt;
    pass2_r  <= pass2_nxt;
    status_r <= status_nxt;
    hour_r   <= hour_nxt;
    min_r    <= min_nxt;
    second_r <= second_nxt;
    wday_r   <= wday_nxt;
    wval_r   <= wval_nxt;
  end

  always_comb begin
    state_nxt  = state_r;
    op_nxt     = op_r;
    now_nxt    = now_r;
    amt_nxt    = amt_r;
    trim_nxt   = cfg_wen ? $signed(cfg_wdata) : trim_r;
    tenth_nxt  = tenth_r;
    smark_nxt  = smark_r;
    sec_nxt    = sec_r;
    days_nxt   = days_r;
    locked_nxt = locked_r;
    year_nxt   = year_r;
    month_nxt  = month_r;
    day_nxt    = day_r;
    doy_nxt    = doy_r;
    leap_nxt   = leap_r;
    pleap_nxt  = pleap_r;
    y4_nxt     = y4_r;
    y100_nxt   = y100_r;
    y400_nxt   = y400_r;
    acc_nxt    = acc_r;
    opnd       = '0;
    s_nxt      = s_r;
    q_nxt      = q_r;
    tq_nxt     = tq_r;
    pass2_nxt  = pass2_r;
    status_nxt = status_r;
    hour_nxt   = hour_r;
    min_nxt    = min_r;
    second_nxt = second_r;
    wday_nxt   = wday_r;
    wval_nxt   = wval_r;
    ovalid_nxt = ovalid_r;
    in_tready  = 1'b0;

    case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          op_nxt    = in_tuser;
          now_nxt   = in_tdata[31:0];
          amt_nxt   = $signed(in_tdata[49:32]);
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        status_nxt = ST_NONE;
        pass2_nxt  = 1'b0;
        acc_nxt    = AW'({1'b0, sec_r});
        state_nxt  = S_BINIT;
        case (op_r)
          OP_SAMPLE: begin
            if (dt_tenth >= 32'(MS_PER_TENTH)) begin
              tenth_nxt  = tenth_r + 32'(MS_PER_TENTH);
              status_nxt = ST_TENTH;
              if (dt_sec >= 32'(MS_PER_SEC) && !dt_sec[31]) begin
                smark_nxt  = smark_r + 32'(MS_PER_SEC);
                status_nxt = ST_SECOND;
                state_nxt  = S_ADDS;
              end
            end
          end
          OP_ADD_SEC: state_nxt = S_ADDS;
          OP_ADD_DAY: begin
            acc_nxt   = days_ext + amt_ext;
            state_nxt = S_SAT;
          end
          OP_MON_UP: begin
            acc_nxt   = days_ext + AW'(mlen);
            state_nxt = S_SAT;
          end
          OP_MON_DN: begin
            acc_nxt = days_ext - AW'(month_len(month_r - 4'd1, leap_r));
            if (acc_nxt > 0) state_nxt = S_SAT;
          end
          OP_YEAR_UP: begin
            acc_nxt   = days_ext + AW'(ylen);
            state_nxt = S_SAT;
          end
          OP_YEAR_DN: begin
            acc_nxt = days_ext - (pleap_r ? AW'(366) : AW'(365));
            if (acc_nxt > 0) state_nxt = S_SAT;
          end
          OP_LOAD_SEC: begin
            acc_nxt   = amt_ext;
            state_nxt = S_LMOD;
          end
          OP_LOAD_DAY: begin
            acc_nxt   = amt_ext;
            state_nxt = S_SAT;
          end
          default: ;
        endcase
      end
      S_ADDS: begin
        opnd      = (op_r == OP_SAMPLE) ? K_ONE : amt_ext;
        s_nxt     = sum;
        acc_nxt   = sum;
        state_nxt = S_HMOD;
      end
      S_HMOD: begin
        if (acc_r >= K_HOUR) begin
          opnd    = -K_HOUR;
          acc_nxt = sum;
        end else if (acc_r <= -K_HOUR) begin
          opnd    = K_HOUR;
          acc_nxt = sum;
        end else if (!pass2_r && acc_r == '0 && !locked_r) begin
          acc_nxt   = trim_mag;
          tq_nxt    = '0;
          state_nxt = S_TDIV;
        end else begin
          if (!s_r[AW-1] && acc_r == K_UNL) locked_nxt = 1'b0;
          acc_nxt   = s_r;
          q_nxt     = '0;
          state_nxt = S_WRAP;
        end
      end
      S_TDIV: begin
        if (acc_r >= K_MS) begin
          opnd    = -K_MS;
          acc_nxt = sum;
          tq_nxt  = tq_r + 5'd1;
        end else begin
          state_nxt = S_TAPPLY;
        end
      end
      S_TAPPLY: begin
        s_nxt      = s_r + tq_s;
        smark_nxt  = trim_r[14] ? smark_r + rem32 : smark_r - rem32;
        locked_nxt = 1'b1;
        pass2_nxt  = 1'b1;
        acc_nxt    = s_nxt;
        state_nxt  = S_HMOD;
      end
      S_WRAP: begin
        if (acc_r[AW-1]) begin
          opnd    = K_DAY;
          acc_nxt = sum;
          q_nxt   = q_r - 3'sd1;
        end else if (acc_r >= K_DAY) begin
          opnd    = -K_DAY;
          acc_nxt = sum;
          q_nxt   = q_r + 3'sd1;
        end else begin
          sec_nxt = acc_r[16:0];
          if (q_r != '0) begin
            status_nxt = ST_MIDNIGHT;
            acc_nxt    = days_ext + AW'(q_r);
            state_nxt  = S_SAT;
          end else begin
            state_nxt = S_BINIT;
          end
        end
      end
      S_SAT: begin
        if (acc_r < K_ONE) days_nxt = DCB'(1);
        else if (acc_r > K_DMAX) days_nxt = K_DMAX[DCB-1:0];
        else days_nxt = acc_r[DCB-1:0];
        state_nxt = S_BINIT;
      end
      S_LMOD: begin
        if (acc_r[AW-1]) begin
          opnd    = K_DAY;
          acc_nxt = sum;
        end else if (acc_r >= K_DAY) begin
          opnd    = -K_DAY;
          acc_nxt = sum;
        end else begin
          sec_nxt   = acc_r[16:0];
          state_nxt = S_BINIT;
        end
      end
      S_BINIT: begin
        acc_nxt   = days_ext;
        year_nxt  = YW'(BASE_YEAR);
        y4_nxt    = 2'(BASE_YEAR % 4);
        y100_nxt  = 7'(BASE_YEAR % 100);
        y400_nxt  = 9'(BASE_YEAR % 400);
        leap_nxt  = BL;
        pleap_nxt = PL;
        state_nxt = S_YEAR;
      end
      S_YEAR: begin
        if (acc_r > AW'(ylen)) begin
          opnd      = -AW'(ylen);
          acc_nxt   = sum;
          year_nxt  = year_r + YW'(1);
          y4_nxt    = n4;
          y100_nxt  = n100;
          y400_nxt  = n400;
          pleap_nxt = leap_r;
          leap_nxt  = (n4 == 2'd0) && ((n100 != 7'd0) || (n400 == 9'd0));
        end else begin
          doy_nxt   = acc_r[8:0];
          month_nxt = 4'd1;
          state_nxt = S_MON;
        end
      end
      S_MON: begin
        if (month_r < 4'd12 && acc_r > AW'(mlen)) begin
          opnd      = -AW'(mlen);
          acc_nxt   = sum;
          month_nxt = month_r + 4'd1;
        end else begin
          day_nxt   = acc_r[4:0];
          wval_nxt  = {1'b0, days_r} + (DCB+1)'(1);
          state_nxt = S_WDAY;
        end
      end
      S_WDAY: begin
        wday_nxt  = wdiff[2:0];
        acc_nxt   = AW'({1'b0, sec_r});
        hour_nxt  = '0;
        state_nxt = S_HOUR;
      end
      S_HOUR: begin
        if (acc_r >= K_HOUR) begin
          opnd     = -K_HOUR;
          acc_nxt  = sum;
          hour_nxt = hour_r + 5'd1;
        end else begin
          min_nxt   = '0;
          state_nxt = S_MIN;
        end
      end
      S_MIN: begin
        if (acc_r >= K_MIN) begin
          opnd    = -K_MIN;
          acc_nxt = sum;
          min_nxt = min_r + 6'd1;
        end else begin
          second_nxt = acc_r[5:0];
          if (op_r == OP_ZERO_SEC) begin
            sec_nxt    = sec_r - {11'd0, acc_r[5:0]};
            second_nxt = '0;
          end
          ovalid_nxt = 1'b1;
          state_nxt  = S_OUT;
        end
      end
      S_OUT: begin
        if (out_tready) begin
          ovalid_nxt = 1'b0;
          state_nxt  = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign out_tvalid = ovalid_r;
  assign out_tuser  = status_r;
  assign out_tdata  = {5'd0, dc_ext[15:0], wday_r, doy_r, year_r[11:0], month_r, day_r,
                       second_r, min_r, hour_r, sec_r};

endmodule
